// File: rtl/chuff_pkg.sv
// Shared types, constants and helpers of the canonical Huffman encoder.
// Used by the front, back and top-level modules; depends on nothing else.
package chuff_pkg;

  // Fixed field widths of the item ports.
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int CNT_W  = 9;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SET    = 2'd1,
    OP_BUILD  = 2'd2,
    OP_ENCODE = 2'd3
  } op_e;

  // Sequencer states of the back end.
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_COUNT,
    BS_CODES,
    BS_ASSIGN,
    BS_RESULT
  } bld_state_e;

  // A classified item as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic             sym_ok;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Mask that keeps the low len bits of a code word.
  function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] ones;
    ones = '1;
    return ~(ones << len);
  endfunction

endpackage

// File: rtl/chuff_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the length and code tables.
module chuff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/chuff_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on chuff_pkg for the item types.
module chuff_front #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     mode_i,
  input  logic [chuff_pkg::SYM_W-1:0]    symbol_i,
  input  logic [chuff_pkg::LEN_W-1:0]    length_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output chuff_pkg::cmd_t                cmd_o
);
  import chuff_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);

  cmd_t            cmd_in;
  cmd_t            queue_q [QDEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  // Classify the item: decode the mode, range-check the symbol and
  // saturate the length to the longest code allowed.
  always_comb begin
    cmd_in.op     = op_e'(mode_i);
    cmd_in.sym    = symbol_i;
    cmd_in.sym_ok = ({1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT));
    cmd_in.len    = (length_i > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : length_i;
  end

  assign in_ready_o  = (cnt_q != (PW + 1)'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (PW + 1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW + 1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/chuff_back.sv
// Back end: executes queued items, runs the code build sequence and holds
// the result register. Depends on chuff_pkg and chuff_ram.
module chuff_back #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  chuff_pkg::cmd_t               cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [chuff_pkg::CODE_W-1:0]  code_bits_o,
  output logic [chuff_pkg::LEN_W-1:0]   code_len_o,
  output logic                          error_o
);
  import chuff_pkg::*;

  localparam int AW  = $clog2(SYMBOL_COUNT);
  localparam int SW  = AW + 1;
  localparam int LIW = $clog2(MAX_CODE_LEN);
  localparam int CQW = CODE_W + 1;
  localparam int CKW = CODE_W + 2;

  bld_state_e          state_q, state_d;

  // Table memories and their ports.
  logic                len_we, len_re;
  logic [AW-1:0]       len_raddr;
  logic [LEN_W-1:0]    len_rdata;
  logic                code_we, code_re;
  logic [CODE_W-1:0]   code_wdata, code_rdata;
  logic                vld_q [SYMBOL_COUNT];
  logic                vld_rd_q;

  // Sweep over the symbols.
  logic [SW-1:0]       sweep_q;
  logic                rd_pend_q;
  logic [AW-1:0]       rd_addr_q;
  logic                sweep_run, sweep_busy, sweep_done, sweep_start;
  logic [LEN_W-1:0]    rd_len;
  logic [LIW-1:0]      rd_idx;

  // Length histogram and canonical code generation.
  logic [CNT_W-1:0]    counts_q [MAX_CODE_LEN];
  logic [CODE_W-1:0]   next_code_q [MAX_CODE_LEN];
  logic [LIW-1:0]      len_idx_q;
  logic [CQW-1:0]      code_q, code_new;
  logic [CNT_W-1:0]    prev_cnt;
  logic [LIW:0]        step_len;
  logic [CKW-1:0]      chk_sum, chk_limit;
  logic                over, err_run_q;

  // Status flags.
  logic                built_q, berr_q;

  // Pending result stage and result register.
  logic                cmd_fire, s1_valid_q, s1_adv, s1_free, s1_load;
  logic                s1_enc_q, s1_hit_q, s1_err_q;
  logic                s1_enc_d, s1_hit_d, s1_err_d;
  logic                out_valid_q, out_err_q, use_hit;
  logic [CODE_W-1:0]   out_bits_q;
  logic [LEN_W-1:0]    out_len_q;

  chuff_ram #(.WIDTH(LEN_W), .DEPTH(SYMBOL_COUNT)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (cmd_i.sym[AW-1:0]),
    .wdata_i (cmd_i.len),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  chuff_ram #(.WIDTH(CODE_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (rd_addr_q),
    .wdata_i (code_wdata),
    .re_i    (code_re),
    .raddr_i (cmd_i.sym[AW-1:0]),
    .rdata_o (code_rdata)
  );

  // Handshake between the queue, the pending stage and the result register.
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_free     = !s1_valid_q || s1_adv;
  assign cmd_ready_o = (state_q == BS_IDLE) && s1_free;
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;

  assign sweep_busy  = (sweep_q != SW'(SYMBOL_COUNT));
  assign sweep_done  = !sweep_busy && !rd_pend_q;
  assign sweep_start = ((state_q == BS_IDLE) && (state_d == BS_COUNT)) ||
                       ((state_q == BS_CODES) && (state_d == BS_ASSIGN));

  // Next state of the build sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (cmd_fire && (cmd_i.op == OP_BUILD)) begin
          state_d = BS_COUNT;
        end
      end
      BS_COUNT: begin
        if (sweep_done) begin
          state_d = BS_CODES;
        end
      end
      BS_CODES: begin
        if (len_idx_q == LIW'(MAX_CODE_LEN - 1)) begin
          state_d = BS_ASSIGN;
        end
      end
      BS_ASSIGN: begin
        if (sweep_done) begin
          state_d = BS_RESULT;
        end
      end
      BS_RESULT: begin
        if (s1_free) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  // Control strobes of the back end in each state.
  always_comb begin
    len_we    = 1'b0;
    len_re    = 1'b0;
    len_raddr = sweep_q[AW-1:0];
    code_re   = 1'b0;
    sweep_run = 1'b0;
    s1_load   = 1'b0;
    s1_enc_d  = 1'b0;
    s1_hit_d  = 1'b0;
    s1_err_d  = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd_i.op)
            OP_CLEAR: begin
              s1_load = 1'b1;
            end
            OP_SET: begin
              s1_load = 1'b1;
              len_we  = cmd_i.sym_ok;
            end
            OP_BUILD: begin
              s1_load = 1'b0;
            end
            OP_ENCODE: begin
              s1_load   = 1'b1;
              len_re    = 1'b1;
              code_re   = 1'b1;
              len_raddr = cmd_i.sym[AW-1:0];
              s1_enc_d  = 1'b1;
              s1_hit_d  = cmd_i.sym_ok && built_q && !berr_q;
              s1_err_d  = !built_q || berr_q;
            end
          endcase
        end
      end
      BS_COUNT, BS_ASSIGN: begin
        len_re    = sweep_busy;
        sweep_run = sweep_busy;
      end
      BS_CODES: begin
        sweep_run = 1'b0;
      end
      BS_RESULT: begin
        s1_load  = s1_free;
        s1_err_d = berr_q;
      end
      default: begin
        sweep_run = 1'b0;
      end
    endcase
  end

  // Length read back during a sweep; an entry never set reads as absent.
  assign rd_len = vld_rd_q ? len_rdata : '0;
  assign rd_idx = LIW'(rd_len - LEN_W'(1));

  // Code written for each symbol in the assignment sweep.
  assign code_we    = (state_q == BS_ASSIGN) && rd_pend_q;
  assign code_wdata = (rd_len != '0) ? (next_code_q[rd_idx] & len_mask(rd_len)) : '0;

  // One length step of the canonical code walk.
  always_comb begin
    prev_cnt  = (len_idx_q == '0) ? '0 : counts_q[LIW'(len_idx_q - LIW'(1))];
    code_new  = CQW'((code_q + CQW'(prev_cnt)) << 1);
    step_len  = {1'b0, len_idx_q} + (LIW + 1)'(1);
    chk_sum   = CKW'(code_new) + CKW'(counts_q[len_idx_q]);
    chk_limit = CKW'(1) << step_len;
    over      = (chk_sum > chk_limit);
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Symbol sweep counter and read pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      rd_pend_q <= 1'b0;
    end else if (sweep_start) begin
      sweep_q   <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      if (sweep_run) begin
        sweep_q <= sweep_q + SW'(1);
      end
      rd_pend_q <= sweep_run;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= sweep_q[AW-1:0];
  end

  // Valid bits of the length table: clear empties the table at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        vld_q[i] <= 1'b0;
      end
      vld_rd_q <= 1'b0;
    end else begin
      if (len_re) begin
        vld_rd_q <= vld_q[len_raddr];
      end
      if (cmd_fire && (cmd_i.op == OP_CLEAR)) begin
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
          vld_q[i] <= 1'b0;
        end
      end else if (len_we) begin
        vld_q[cmd_i.sym[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Histogram of code lengths, rebuilt by every build.
  always_ff @(posedge clk_i) begin
    if (cmd_fire && (cmd_i.op == OP_BUILD)) begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
        counts_q[i] <= '0;
      end
    end else if ((state_q == BS_COUNT) && rd_pend_q && (rd_len != '0)) begin
      counts_q[rd_idx] <= counts_q[rd_idx] + CNT_W'(1);
    end
  end

  // First code of each length, then stepped as symbols take codes.
  always_ff @(posedge clk_i) begin
    if (state_q == BS_CODES) begin
      next_code_q[len_idx_q] <= code_new[CODE_W-1:0];
    end else if (code_we && (rd_len != '0)) begin
      next_code_q[rd_idx] <= next_code_q[rd_idx] + CODE_W'(1);
    end
  end

  // Running code and oversubscription check of the length walk.
  always_ff @(posedge clk_i) begin
    if (state_q == BS_COUNT) begin
      code_q <= '0;
    end else if (state_q == BS_CODES) begin
      code_q <= code_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_idx_q <= '0;
      err_run_q <= 1'b0;
    end else if (state_q == BS_COUNT) begin
      len_idx_q <= '0;
      err_run_q <= 1'b0;
    end else if (state_q == BS_CODES) begin
      len_idx_q <= len_idx_q + LIW'(1);
      err_run_q <= err_run_q || over;
    end
  end

  // Build status: set items invalidate the codes, clear resets both flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      built_q <= 1'b0;
      berr_q  <= 1'b0;
    end else if (cmd_fire && (cmd_i.op == OP_CLEAR)) begin
      built_q <= 1'b0;
      berr_q  <= 1'b0;
    end else if (cmd_fire && (cmd_i.op == OP_SET)) begin
      built_q <= 1'b0;
    end else if ((state_q == BS_ASSIGN) && sweep_done) begin
      built_q <= 1'b1;
      berr_q  <= err_run_q;
    end
  end

  // Pending stage: holds the item while the registered table read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_enc_q <= s1_enc_d;
      s1_hit_q <= s1_hit_d;
      s1_err_q <= s1_err_d;
    end
  end

  // Result register.
  assign use_hit = s1_enc_q && s1_hit_q && vld_rd_q && (len_rdata != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_len_q  <= use_hit ? len_rdata : '0;
      out_bits_q <= use_hit ? code_rdata : '0;
      out_err_q  <= s1_err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_bits_o = out_bits_q;
  assign code_len_o  = out_len_q;
  assign error_o     = out_err_q;

  // An item that reports an error never carries a code.
  a_err_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_len_q == '0))
    else $error("error result carries a code length");

  // Code bits above the code length are always zero.
  a_code_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_bits_q & ~len_mask(out_len_q)) == '0))
    else $error("code bits exceed the code length");

  // No code is longer than the configured maximum.
  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_len_q <= LEN_W'(MAX_CODE_LEN)))
    else $error("code length above maximum");

  // A clear item drops both build flags.
  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && (cmd_i.op == OP_CLEAR)) |=> (!built_q && !berr_q))
    else $error("build flags survive a clear");

  // The build result is only reported once the codes are marked built.
  a_result_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_RESULT) |-> built_q)
    else $error("build result before codes are built");

endmodule

// File: rtl/canonical_huffman_encoder.sv
// Top level of the canonical Huffman code table and encoder.
// Depends on chuff_pkg, chuff_front, chuff_back and chuff_ram.

// Each input item is one of four operations chosen by mode_i: clear the
// length table, set the code length of one symbol, build the canonical
// codes, or encode one symbol; every item gives exactly one result item.
// Items pass through a two-entry queue into the execution unit, which
// reads the length and code memories and registers the result. Clear, set
// and encode items are taken one per cycle while the output is not stalled,
// and an encode result passes through the pending stage and the result register.
// A build walks the length memory twice through its single read port and
// steps once per code length in between, so it occupies the execution
// unit and items that follow it wait in the queue. Clearing is immediate,
// because the length table carries a valid bit per entry, and no clearing
// pass follows reset.
module canonical_huffman_encoder #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [chuff_pkg::SYM_W-1:0]   symbol_i,
  input  logic [chuff_pkg::LEN_W-1:0]   length_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [chuff_pkg::CODE_W-1:0]  code_bits_o,
  output logic [chuff_pkg::LEN_W-1:0]   code_len_o,
  output logic                          error_o
);
  import chuff_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  // Item intake, classification and queue.
  chuff_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .symbol_i    (symbol_i),
    .length_i    (length_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Table memories, build sequencer and result register.
  chuff_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_bits_o (code_bits_o),
    .code_len_o  (code_len_o),
    .error_o     (error_o)
  );

endmodule
